// File: design/pkc_pkg.sv
// ---------------------------------------------------------------------------
// pkc_pkg
// Shared types and constants for the peak step counter.
// ---------------------------------------------------------------------------
`default_nettype none

package pkc_pkg;

    localparam int MAG_W    = 16;
    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 20;
    localparam int DIST_W   = 28;
    localparam int CAL_W    = 16;
    localparam int STRIDE_W = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 20'hFFFFF;

    // count / 25 as (count * CAL_MULT) >> CAL_SHIFT, exact for 20-bit counts
    localparam int CAL_MULT_W = 21;
    localparam int CAL_SHIFT  = 25;
    localparam logic [CAL_MULT_W-1:0] CAL_MULT = 21'd1342178;
    localparam int CALP_W = COUNT_W + CAL_MULT_W;

    localparam logic [3:0] DIGIT_LAST = 4'd9;

    localparam logic [CFG_IDX_W-1:0] REG_PEAK_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_MAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE    = 3'd4;

    localparam logic [MAG_W-1:0]    PEAK_MIN_RST = 16'd307;
    localparam logic [MAG_W-1:0]    PEAK_MAX_RST = 16'd896;
    localparam logic [15:0]         GAP_MIN_RST  = 16'd300;
    localparam logic [15:0]         GAP_MAX_RST  = 16'd2000;
    localparam logic [STRIDE_W-1:0] STRIDE_RST   = 8'd75;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_MATH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic rotate;
    } chain_ctl_t;

endpackage

`default_nettype wire

// File: design/pkc_if.sv
// ---------------------------------------------------------------------------
// pkc_if
// Sample and result channels of the peak step counter.
// ---------------------------------------------------------------------------
`default_nettype none

interface pkc_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] magnitude;
    logic [31:0] time_ms;

    modport source (output valid, output op, output magnitude, output time_ms,
                    input ready);
    modport sink   (input valid, input op, input magnitude, input time_ms,
                    output ready);
endinterface

interface pkc_out_if;
    logic        valid;
    logic        ready;
    logic        step_found;
    logic [19:0] step_total;
    logic [27:0] distance_cm;
    logic [15:0] calories;
    logic        report_due;

    modport source (output valid, output step_found, output step_total,
                    output distance_cm, output calories, output report_due,
                    input ready);
    modport sink   (input valid, input step_found, input step_total,
                    input distance_cm, input calories, input report_due,
                    output ready);
endinterface

`default_nettype wire

// File: design/pkc_cell.sv
// ---------------------------------------------------------------------------
// pkc_cell
// One sample cell of the ring; takes its neighbor's sample when enabled.
// ---------------------------------------------------------------------------
`default_nettype none

module pkc_cell (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic [pkc_pkg::MAG_W-1:0] din,
    output logic      [pkc_pkg::MAG_W-1:0] q
);

    logic [pkc_pkg::MAG_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= din;
        end
    end

    assign q = data_reg;

endmodule

`default_nettype wire

// File: design/pkc_chain.sv
// ---------------------------------------------------------------------------
// pkc_chain
// Row of sample cells. Load shifts a new sample in at cell 0; rotate moves
// every sample one cell on, last cell wrapping to the first.
// ---------------------------------------------------------------------------
`default_nettype none

module pkc_chain #(
    parameter int DEPTH = 10
) (
    input  wire logic                      clk,
    input  wire pkc_pkg::chain_ctl_t       ctl,
    input  wire logic [pkc_pkg::MAG_W-1:0] sample_in,
    output logic      [pkc_pkg::MAG_W-1:0] head,
    output logic      [pkc_pkg::MAG_W-1:0] tap
);

    logic [pkc_pkg::MAG_W-1:0] link [DEPTH];
    logic [pkc_pkg::MAG_W-1:0] first_din;
    logic                      shift_en;

    assign shift_en  = ctl.load | ctl.rotate;
    assign first_din = ctl.load ? sample_in : link[DEPTH-1];

    pkc_cell u_cell0 (
        .clk (clk),
        .en  (shift_en),
        .din (first_din),
        .q   (link[0])
    );

    for (genvar i = 1; i < DEPTH; i++)
    begin : g_cell
        pkc_cell u_cell (
            .clk (clk),
            .en  (shift_en),
            .din (link[i-1]),
            .q   (link[i])
        );
    end

    assign head = link[DEPTH-1];
    assign tap  = link[0];

endmodule

`default_nettype wire

// File: design/peak_step_counter.sv
// ---------------------------------------------------------------------------
// peak_step_counter
// Pedometer step counter by peak detection over a ring of samples.
// ---------------------------------------------------------------------------
// A magnitude sample is processed in steps after acceptance: the ring is a
// chain of cells that rotates one place per cycle past a single 16-bit
// comparator to check the candidate peak, then the interval check, the
// distance and calorie multiplies, and the result register, which waits
// while an earlier result is still untaken. A daily reset item skips the
// scan. One item is in work at a time; the next is taken once the previous
// result sits in the output register, even if not yet taken.
`default_nettype none

module peak_step_counter #(
    parameter int RING_DEPTH = 10
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [pkc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pkc_pkg::CFG_DATA_W-1:0] cfg_data,
    pkc_in_if.sink                              sample,
    pkc_out_if.source                           result
);

    localparam int POS_W  = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);

    pkc_pkg::state_t state_reg, state_next;

    logic [pkc_pkg::MAG_W-1:0]    peak_min_reg, peak_max_reg;
    logic [15:0]                  gap_min_reg, gap_max_reg;
    logic [pkc_pkg::STRIDE_W-1:0] stride_reg;

    logic                          op_reg;
    logic [pkc_pkg::TIME_W-1:0]    time_reg;
    logic [pkc_pkg::MAG_W-1:0]     cand_reg;
    logic                          peak_ok_reg;
    logic [POS_W-1:0]              pos_reg;
    logic [FILL_W-1:0]             fill_reg;
    logic [pkc_pkg::TIME_W-1:0]    last_reg;
    logic                          have_reg;
    logic [pkc_pkg::COUNT_W-1:0]   count_reg;
    logic [3:0]                    digit_reg;
    logic                          counted_reg;
    logic                          report_reg;
    logic [pkc_pkg::DIST_W-1:0]    dist_reg;
    logic [pkc_pkg::CALP_W-1:0]    calp_reg;

    logic                          out_valid_reg;
    logic                          out_found_reg;
    logic [pkc_pkg::COUNT_W-1:0]   out_total_reg;
    logic [pkc_pkg::DIST_W-1:0]    out_dist_reg;
    logic [pkc_pkg::CAL_W-1:0]     out_cal_reg;
    logic                          out_report_reg;

    pkc_pkg::chain_ctl_t           chain_ctl;
    logic [pkc_pkg::MAG_W-1:0]     head, tap;
    logic                          accept;
    logic                          scan_fail;
    logic                          scan_last;
    logic                          done_fire;
    logic                          is_step;
    logic [pkc_pkg::TIME_W-1:0]    gap;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_min_reg <= pkc_pkg::PEAK_MIN_RST;
            peak_max_reg <= pkc_pkg::PEAK_MAX_RST;
            gap_min_reg  <= pkc_pkg::GAP_MIN_RST;
            gap_max_reg  <= pkc_pkg::GAP_MAX_RST;
            stride_reg   <= pkc_pkg::STRIDE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pkc_pkg::REG_PEAK_MIN: peak_min_reg <= cfg_data;
                pkc_pkg::REG_PEAK_MAX: peak_max_reg <= cfg_data;
                pkc_pkg::REG_GAP_MIN:  gap_min_reg  <= cfg_data;
                pkc_pkg::REG_GAP_MAX:  gap_max_reg  <= cfg_data;
                pkc_pkg::REG_STRIDE:   stride_reg   <= cfg_data[pkc_pkg::STRIDE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- sample chain ----------------
    pkc_chain #(
        .DEPTH (RING_DEPTH)
    ) u_chain (
        .clk       (clk),
        .ctl       (chain_ctl),
        .sample_in (sample.magnitude),
        .head      (head),
        .tap       (tap)
    );

    // ---------------- control ----------------
    assign scan_last = (pos_reg == '0);
    assign done_fire = (state_reg == pkc_pkg::ST_DONE) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pkc_pkg::ST_IDLE:
                if (sample.valid)
                begin
                    state_next = (sample.op == pkc_pkg::OP_CLEAR) ? pkc_pkg::ST_DECIDE
                                                                  : pkc_pkg::ST_SCAN;
                end
            pkc_pkg::ST_SCAN:
                if (scan_last)
                begin
                    state_next = pkc_pkg::ST_DECIDE;
                end
            pkc_pkg::ST_DECIDE: state_next = pkc_pkg::ST_MATH;
            pkc_pkg::ST_MATH:   state_next = pkc_pkg::ST_DONE;
            pkc_pkg::ST_DONE:
                if (done_fire)
                begin
                    state_next = pkc_pkg::ST_IDLE;
                end
            default: state_next = pkc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        sample.ready     = (state_reg == pkc_pkg::ST_IDLE);
        accept           = sample.valid && sample.ready;
        chain_ctl.load   = accept && (sample.op == pkc_pkg::OP_SAMPLE);
        chain_ctl.rotate = (state_reg == pkc_pkg::ST_SCAN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pkc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------- item capture and peak scan ----------------
    // head holds the entry at ring position pos_reg; position 1 is the candidate
    assign scan_fail = (pos_reg != POS_W'(1)) && (FILL_W'(pos_reg) < fill_reg)
                       && (head >= cand_reg);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= sample.op;
            time_reg <= sample.time_ms;
            cand_reg <= tap;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            pos_reg     <= '0;
            peak_ok_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg     <= POS_W'(RING_DEPTH - 1);
            peak_ok_reg <= 1'b1;
            if (chain_ctl.load && (fill_reg != FILL_W'(RING_DEPTH)))
            begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
        else if (chain_ctl.rotate)
        begin
            pos_reg <= pos_reg - 1'b1;
            if (scan_fail)
            begin
                peak_ok_reg <= 1'b0;
            end
        end
    end

    // ---------------- step decision ----------------
    assign is_step = (op_reg == pkc_pkg::OP_SAMPLE) && peak_ok_reg
                     && (fill_reg >= FILL_W'(3))
                     && (cand_reg >= peak_min_reg) && (cand_reg <= peak_max_reg);
    assign gap = time_reg - last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg    <= '0;
            have_reg    <= 1'b0;
            count_reg   <= '0;
            digit_reg   <= '0;
            counted_reg <= 1'b0;
            report_reg  <= 1'b0;
        end
        else if (state_reg == pkc_pkg::ST_DECIDE)
        begin
            counted_reg <= 1'b0;
            report_reg  <= 1'b0;
            if (op_reg == pkc_pkg::OP_CLEAR)
            begin
                count_reg <= '0;
                digit_reg <= '0;
            end
            else if (is_step)
            begin
                priority if (have_reg && (gap > 32'(gap_max_reg)))
                begin
                    last_reg <= time_reg;
                end
                else if (!have_reg || (gap >= 32'(gap_min_reg)))
                begin
                    counted_reg <= 1'b1;
                    have_reg    <= 1'b1;
                    last_reg    <= time_reg;
                    if (count_reg != pkc_pkg::COUNT_MAX)
                    begin
                        count_reg <= count_reg + 1'b1;
                        if (digit_reg == pkc_pkg::DIGIT_LAST)
                        begin
                            digit_reg  <= '0;
                            report_reg <= 1'b1;
                        end
                        else
                        begin
                            digit_reg <= digit_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                end
            end
        end
    end

    // ---------------- totals ----------------
    always_ff @(posedge clk)
    begin
        if (state_reg == pkc_pkg::ST_MATH)
        begin
            dist_reg <= pkc_pkg::DIST_W'(count_reg) * pkc_pkg::DIST_W'(stride_reg);
            calp_reg <= pkc_pkg::CALP_W'(count_reg) * pkc_pkg::CALP_W'(pkc_pkg::CAL_MULT);
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_fire)
        begin
            out_found_reg  <= counted_reg;
            out_total_reg  <= count_reg;
            out_dist_reg   <= dist_reg;
            out_cal_reg    <= calp_reg[pkc_pkg::CAL_SHIFT +: pkc_pkg::CAL_W];
            out_report_reg <= report_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.step_found  = out_found_reg;
    assign result.step_total  = out_total_reg;
    assign result.distance_cm = out_dist_reg;
    assign result.calories    = out_cal_reg;
    assign result.report_due  = out_report_reg;

    // ---------------- assertions ----------------
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(RING_DEPTH))
        else $error("ring fill count beyond depth");

    a_report_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
        report_reg |-> counted_reg)
        else $error("report flagged without a counted step");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pkc_pkg::ST_DECIDE && op_reg == pkc_pkg::OP_SAMPLE)
        |=> count_reg >= $past(count_reg))
        else $error("step count dropped on a sample item");

    a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.step_found) |-> (result.step_total != '0))
        else $error("step found with zero total");

    a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pkc_pkg::ST_SCAN && scan_last) |=> state_reg == pkc_pkg::ST_DECIDE)
        else $error("scan did not end after last cell");

endmodule

`default_nettype wire
